>>> hw/rtl/dfia_pkg.sv
// Shared types and constants of the deferred free index allocator.
package dfia_pkg;

    localparam int CAPACITY   = 1024;
    localparam int PEND_DEPTH = 1024;

    localparam int ADDR_W = 64;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int INC_W  = 13;
    localparam int OFF_W  = IDX_W + INC_W;
    localparam int SPAN_W = CNT_W + INC_W;
    localparam int SAW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PAW    = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int PCW    = $clog2(PEND_DEPTH + 1);
    localparam int BIT_W  = $clog2(IDX_W);

    localparam logic [1:0] MODE_ALLOC     = 2'd0;
    localparam logic [1:0] MODE_FREE_IDX  = 2'd1;
    localparam logic [1:0] MODE_FREE_ADDR = 2'd2;
    localparam logic [1:0] MODE_FINISH    = 2'd3;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE_IDX  = 2'd1,
        OP_FREE_ADDR = 2'd2,
        OP_FINISH    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_RANGE   = 3'd2,
        ST_QFULL   = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_CPU_BASE   = 3'd0,
        CFG_GPU_BASE   = 3'd1,
        CFG_INCREMENT  = 3'd2,
        CFG_SLOT_LIMIT = 3'd3,
        CFG_SHADER_VIS = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   slot;
        logic               hv;
        logic [ADDR_W-1:0]  caddr;
        logic [ADDR_W-1:0]  fence;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]  cpu_base;
        logic [ADDR_W-1:0]  gpu_base;
        logic [INC_W-1:0]   inc;
        logic [CNT_W-1:0]   limit;
        logic               vis;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]   slot;
        logic [ADDR_W-1:0]  fence;
    } t_pend;

endpackage

>>> hw/rtl/deferred_free_index_allocator_core.sv
// Top level of the deferred free index allocator: configuration registers and the two ends.
// Slot allocator with deferred reclamation. A transaction is taken when start is high and busy
// low; a two-entry command queue lets up to two transactions wait while the back end works,
// and busy rises only when that queue is full. Each transaction gives exactly one result,
// shown for one cycle with o_valid; results come in transaction order and cannot be held off.
// Steps in the back end, set by its sequencer: allocate from the free stack reads the stack
// memory, multiplies and adds; allocate of a fresh index multiplies and adds; out of space and
// free by index give their result straight from the idle state; free by CPU address does a range
// check then a one-bit-per-cycle divider over ten quotient bits; finish frame does one pending-queue
// read per entry drained, and stops when an entry whose fence is still ahead is met.
// Configuration writes are always accepted (o_cfg_ready is high) and belong between
// transactions. Stored slot entries need no clearing after reset.
module deferred_free_index_allocator_core import dfia_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [IDX_W-1:0]   i_slot_index,
    input  logic               i_handle_valid,
    input  logic [ADDR_W-1:0]  i_cpu_address,
    input  logic [ADDR_W-1:0]  i_fence_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [ADDR_W-1:0]  i_cfg_data,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_out_index,
    output logic [ADDR_W-1:0]  o_out_cpu_address,
    output logic [ADDR_W-1:0]  o_out_gpu_address,
    output logic [2:0]         o_status,
    output logic [CNT_W-1:0]   o_moved_count
);

    t_cfg    r_cfg;
    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_cmd_pop;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cpu_base <= '0;
            r_cfg.gpu_base <= '0;
            r_cfg.inc      <= INC_W'(32);
            r_cfg.limit    <= CNT_W'(1024);
            r_cfg.vis      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CPU_BASE:   r_cfg.cpu_base <= i_cfg_data;
                CFG_GPU_BASE:   r_cfg.gpu_base <= i_cfg_data;
                CFG_INCREMENT:  r_cfg.inc      <= i_cfg_data[INC_W-1:0];
                CFG_SLOT_LIMIT: r_cfg.limit    <= i_cfg_data[CNT_W-1:0];
                CFG_SHADER_VIS: r_cfg.vis      <= i_cfg_data[0];
                default:        r_cfg          <= r_cfg;
            endcase
        end
    end

    dfia_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_mode         (i_mode),
        .i_slot_index   (i_slot_index),
        .i_handle_valid (i_handle_valid),
        .i_cpu_address  (i_cpu_address),
        .i_fence_value  (i_fence_value),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_pop      (w_cmd_pop)
    );

    dfia_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (w_cmd_valid),
        .i_cmd             (w_cmd),
        .o_cmd_pop         (w_cmd_pop),
        .i_cfg             (r_cfg),
        .o_valid           (o_valid),
        .o_out_index       (o_out_index),
        .o_out_cpu_address (o_out_cpu_address),
        .o_out_gpu_address (o_out_gpu_address),
        .o_status          (w_status),
        .o_moved_count     (o_moved_count)
    );

    assign o_status = w_status;

endmodule

>>> hw/rtl/dfia_front.sv
// Front end: takes commands, decodes the mode and queues them for the back end.
module dfia_front import dfia_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_mode,
    input  logic [IDX_W-1:0]   i_slot_index,
    input  logic               i_handle_valid,
    input  logic [ADDR_W-1:0]  i_cpu_address,
    input  logic [ADDR_W-1:0]  i_fence_value,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_op        w_op;
    logic       w_push;

    always_comb begin
        case (i_mode)
            MODE_ALLOC:     w_op = OP_ALLOC;
            MODE_FREE_IDX:  w_op = OP_FREE_IDX;
            MODE_FREE_ADDR: w_op = OP_FREE_ADDR;
            MODE_FINISH:    w_op = OP_FINISH;
            default:        w_op = OP_FINISH;
        endcase
    end

    assign o_busy      = (r_cnt == 2'd2);
    assign w_push      = i_start && !o_busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{op: w_op, slot: i_slot_index, hv: i_handle_valid,
                           caddr: i_cpu_address, fence: i_fence_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_cmd_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> hw/rtl/dfia_back.sv
// Back end: free stack, pending queue, address arithmetic and the drain loop.
module dfia_back import dfia_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_out_index,
    output logic [ADDR_W-1:0]  o_out_cpu_address,
    output logic [ADDR_W-1:0]  o_out_gpu_address,
    output t_status            o_status,
    output logic [CNT_W-1:0]   o_moved_count
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ALRD = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_ADD  = 8'b0000_1000,
        S_ACHK = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_FRD  = 8'b0100_0000,
        S_FCHK = 8'b1000_0000
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_free_count;
    logic [CNT_W-1:0]    r_fresh;
    logic [PAW-1:0]      r_head;
    logic [PAW-1:0]      r_tail;
    logic [PCW-1:0]      r_pcnt;
    logic [IDX_W-1:0]    r_idx;
    logic [OFF_W-1:0]    r_off;
    logic [ADDR_W-1:0]   r_fence;
    logic [ADDR_W-1:0]   r_diff;
    logic                r_below;
    logic [SPAN_W-1:0]   r_span;
    logic [SPAN_W-1:0]   r_rem;
    logic [SPAN_W-1:0]   r_dvs;
    logic [IDX_W-1:0]    r_q;
    logic [BIT_W-1:0]    r_bit;
    logic [CNT_W-1:0]    r_moved;
    logic [IDX_W-1:0]    r_stk_q;
    t_pend               r_pq;

    logic                r_o_valid;
    logic [IDX_W-1:0]    r_o_index;
    logic [ADDR_W-1:0]   r_o_cpu;
    logic [ADDR_W-1:0]   r_o_gpu;
    t_status             r_o_status;
    logic [CNT_W-1:0]    r_o_moved;

    logic [IDX_W-1:0]    m_stack [CAPACITY];
    t_pend               m_pend  [PEND_DEPTH];

    logic [CNT_W-1:0]    w_lim;
    logic                w_ge;
    logic [IDX_W-1:0]    w_q_next;
    logic                w_pend_full;
    logic                w_enq;
    t_pend               w_enq_data;
    logic                w_move;
    logic [SAW-1:0]      w_stk_raddr;
    logic [PAW-1:0]      w_head_nx;
    logic [PAW-1:0]      w_tail_nx;

    always_comb begin
        w_lim       = (i_cfg.limit < CNT_W'(CAPACITY)) ? i_cfg.limit : CNT_W'(CAPACITY);
        o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
        w_ge        = (r_rem >= r_dvs);
        w_q_next    = {r_q[IDX_W-2:0], w_ge};
        w_pend_full = (r_pcnt == PCW'(PEND_DEPTH));
        w_enq       = !w_pend_full &&
                      ((o_cmd_pop && i_cmd.op == OP_FREE_IDX && i_cmd.hv) ||
                       (r_state == S_DIV && r_bit == '0));
        w_enq_data.slot  = (r_state == S_IDLE) ? i_cmd.slot : w_q_next;
        w_enq_data.fence = (r_state == S_IDLE) ? i_cmd.fence : r_fence;
        w_move      = (r_state == S_FCHK) && (r_pq.fence <= r_fence);
        w_stk_raddr = SAW'(r_free_count - CNT_W'(1));
        w_head_nx   = (r_head == PAW'(PEND_DEPTH - 1)) ? '0 : r_head + PAW'(1);
        w_tail_nx   = (r_tail == PAW'(PEND_DEPTH - 1)) ? '0 : r_tail + PAW'(1);
    end

    // storage: one write and one registered read per memory
    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            m_pend[r_tail] <= w_enq_data;
        end
        r_pq <= m_pend[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            m_stack[SAW'(r_free_count)] <= r_pq.slot;
        end
        r_stk_q <= m_stack[w_stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= '0;
            r_fresh      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_pcnt       <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (w_enq) begin
                r_tail <= w_tail_nx;
                r_pcnt <= r_pcnt + PCW'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_fence    <= i_cmd.fence;
                        r_moved    <= '0;
                        r_o_index  <= '0;
                        r_o_cpu    <= '0;
                        r_o_gpu    <= '0;
                        r_o_moved  <= '0;
                        r_o_status <= ST_OK;
                        case (i_cmd.op)
                            OP_ALLOC: begin
                                if (r_free_count != '0) begin
                                    r_free_count <= r_free_count - CNT_W'(1);
                                    r_state      <= S_ALRD;
                                end else if (r_fresh < w_lim) begin
                                    r_idx   <= r_fresh[IDX_W-1:0];
                                    r_fresh <= r_fresh + CNT_W'(1);
                                    r_state <= S_MUL;
                                end else begin
                                    r_o_status <= ST_NOSPACE;
                                    r_o_valid  <= 1'b1;
                                end
                            end
                            OP_FREE_IDX: begin
                                r_o_valid <= 1'b1;
                                if (!i_cmd.hv) begin
                                    r_o_status <= ST_INVALID;
                                end else begin
                                    r_o_index  <= i_cmd.slot;
                                    r_o_status <= w_pend_full ? ST_QFULL : ST_OK;
                                end
                            end
                            OP_FREE_ADDR: begin
                                r_diff  <= i_cmd.caddr - i_cfg.cpu_base;
                                r_below <= (i_cmd.caddr < i_cfg.cpu_base);
                                r_span  <= w_lim * i_cfg.inc;
                                r_state <= S_ACHK;
                            end
                            OP_FINISH: begin
                                r_state <= S_FRD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ALRD: begin
                    r_idx   <= r_stk_q;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_off   <= r_idx * i_cfg.inc;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_o_index <= r_idx;
                    r_o_cpu   <= i_cfg.cpu_base + ADDR_W'(r_off);
                    r_o_gpu   <= i_cfg.vis ? i_cfg.gpu_base + ADDR_W'(r_off) : '0;
                    r_o_valid <= 1'b1;
                    r_state   <= S_IDLE;
                end
                S_ACHK: begin
                    if (i_cfg.inc == '0 || r_below || r_diff >= ADDR_W'(r_span)) begin
                        r_o_status <= ST_RANGE;
                        r_o_valid  <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_rem   <= SPAN_W'(r_diff);
                        r_dvs   <= SPAN_W'(i_cfg.inc) << (IDX_W - 1);
                        r_bit   <= BIT_W'(IDX_W - 1);
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle, most significant first
                    if (w_ge) begin
                        r_rem <= r_rem - r_dvs;
                    end
                    r_dvs <= r_dvs >> 1;
                    r_q   <= w_q_next;
                    r_bit <= r_bit - BIT_W'(1);
                    if (r_bit == '0) begin
                        r_o_index  <= w_q_next;
                        r_o_status <= w_pend_full ? ST_QFULL : ST_OK;
                        r_o_valid  <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_FRD: begin
                    if (r_pcnt != '0 && r_free_count < CNT_W'(CAPACITY)) begin
                        r_state <= S_FCHK;
                    end else begin
                        r_o_moved <= r_moved;
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_FCHK: begin
                    if (w_move) begin
                        r_free_count <= r_free_count + CNT_W'(1);
                        r_head       <= w_head_nx;
                        r_pcnt       <= r_pcnt - PCW'(1);
                        r_moved      <= r_moved + CNT_W'(1);
                        r_state      <= S_FRD;
                    end else begin
                        r_o_moved <= r_moved;
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_o_valid;
    assign o_out_index       = r_o_index;
    assign o_out_cpu_address = r_o_cpu;
    assign o_out_gpu_address = r_o_gpu;
    assign o_status          = r_o_status;
    assign o_moved_count     = r_o_moved;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= CNT_W'(CAPACITY))
        else $error("free stack count beyond capacity");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= PCW'(PEND_DEPTH))
        else $error("pending count beyond depth");

    a_pend_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt == '0 |-> r_head == r_tail)
        else $error("empty pending queue with head and tail apart");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_state == S_IDLE)
        else $error("result issued while a transaction is still in progress");

    a_no_move_on_enq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_move && w_enq))
        else $error("drain and enqueue in the same cycle");

endmodule
